// File: rtl/dlr_pkg.sv
// Shared types, field widths and status codes for the data run list decoder.
`timescale 1ns / 1ps
`default_nettype none
package dlr_pkg;

    localparam int BYTE_W       = 8;
    localparam int TARGET_W     = 48;
    localparam int CLUSTER_W    = 48;
    localparam int STATUS_W     = 3;
    localparam int BASE_W       = 64;
    localparam int CLUSTER_BITS = 48;
    localparam int NIB_W        = 4;
    localparam int IDX_W        = 3;
    localparam int LANES        = 8;

    localparam logic [STATUS_W-1:0] ST_MAPPED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_SPARSE = 3'd1;
    localparam logic [STATUS_W-1:0] ST_END    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_WIDE   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NEG    = 3'd4;

    // Pre-decoded request passed from the front end to the back end
    typedef struct packed {
        logic [BYTE_W-1:0]   run_byte;
        logic                start;
        logic [TARGET_W-1:0] target;
        logic                hdr_zero;
        logic                hdr_wide;
        logic [NIB_W-1:0]    len_size;
        logic [NIB_W-1:0]    off_size;
    } cmd_t;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [CLUSTER_W-1:0] cluster;
    } res_t;

    typedef struct packed {
        logic cmd_pop;
        logic res_push;
    } bk_ctl_t;

endpackage
`default_nettype wire

// File: rtl/data_run_list_decoder_top.sv
// Data run list decoder: top level with front end, request queue, walker and result queue.
// Throughput: one run-list byte per cycle, sustained while the result queue is not full.
// Path: the byte that ends the lookup passes the front-end register and the request queue,
//   then the walker step writes its result into the result queue, which drives the ports.
// Reset: rst_n is asynchronous and active low; it empties both queues and puts the
//   walker back to idle. No clearing pass; requests are accepted straight after reset.
`timescale 1ns / 1ps
`default_nettype none
module data_run_list_decoder_top #(
    parameter int FIELD_BYTES = 8,  // widest length or delta field, 1 to 8 bytes
    parameter int CMD_DEPTH   = 4,  // request queue depth, power of two
    parameter int RES_DEPTH   = 2   // result queue depth, power of two
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            push,
    output logic                                 full,
    input  wire logic [dlr_pkg::BYTE_W-1:0]      run_byte,
    input  wire logic                            start_lookup,
    input  wire logic [dlr_pkg::TARGET_W-1:0]    target_rel,
    output logic                                 empty,
    input  wire logic                            pop,
    output logic [dlr_pkg::STATUS_W-1:0]         status,
    output logic [dlr_pkg::CLUSTER_W-1:0]        cluster
);

    // front end: one register stage, decodes header nibbles up front
    logic             cmd_push, cmd_full, cmd_empty;
    dlr_pkg::cmd_t    cmd_in, cmd_out;
    dlr_pkg::res_t    res_in, res_out;
    dlr_pkg::bk_ctl_t bk_ctl;
    logic             res_full;

    dlr_front #(
        .FIELD_BYTES (FIELD_BYTES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_push   (push),
        .in_byte   (run_byte),
        .in_start  (start_lookup),
        .in_target (target_rel),
        .in_full   (full),
        .cmd_push  (cmd_push),
        .cmd       (cmd_in),
        .cmd_full  (cmd_full)
    );

    // request queue decouples decoding from the walker
    dlr_fifo #(
        .WIDTH ($bits(dlr_pkg::cmd_t)),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cmd_push),
        .din   (cmd_in),
        .full  (cmd_full),
        .pop   (bk_ctl.cmd_pop),
        .dout  (cmd_out),
        .empty (cmd_empty)
    );

    // walker: takes a request only when a result slot is free
    dlr_back #(
        .FIELD_BYTES (FIELD_BYTES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_out),
        .cmd_empty (cmd_empty),
        .res_full  (res_full),
        .res       (res_in),
        .ctl       (bk_ctl)
    );

    // result queue: the walker keeps going while a result waits to be taken
    dlr_fifo #(
        .WIDTH ($bits(dlr_pkg::res_t)),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (bk_ctl.res_push),
        .din   (res_in),
        .full  (res_full),
        .pop   (pop),
        .dout  (res_out),
        .empty (empty)
    );

    assign status  = res_out.status;
    assign cluster = res_out.cluster;

    // a result is only ever produced by a request taken from the queue
    a_push_needs_pop: assert property (@(posedge clk) disable iff (!rst_n)
        bk_ctl.res_push |-> bk_ctl.cmd_pop)
        else $error("result without a request");

    // the walker never steps while the result queue is full
    a_no_step_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        res_full |-> !bk_ctl.cmd_pop)
        else $error("walker stepped with result queue full");

    // only a mapped result carries a cluster
    a_cluster_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && status != dlr_pkg::ST_MAPPED) |-> cluster == '0)
        else $error("non-zero cluster on unmapped result");

    // status codes stay within the defined set
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (status == dlr_pkg::ST_MAPPED || status == dlr_pkg::ST_SPARSE ||
                    status == dlr_pkg::ST_END || status == dlr_pkg::ST_WIDE ||
                    status == dlr_pkg::ST_NEG))
        else $error("undefined status code");

endmodule
`default_nettype wire

// File: rtl/dlr_fifo.sv
// Small register queue with first-word fall-through read.
`timescale 1ns / 1ps
`default_nettype none
module dlr_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4   // power of two
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] din,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      dout,
    output logic                  empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full    = (cnt_reg == CNT_W'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? PTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? PTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = CNT_W'(cnt_reg + 1'b1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = CNT_W'(cnt_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

endmodule
`default_nettype wire

// File: rtl/dlr_front.sv
// Front end: registers each input byte and decodes its header nibbles.
`timescale 1ns / 1ps
`default_nettype none
module dlr_front #(
    parameter int FIELD_BYTES = 8
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_push,
    input  wire logic [dlr_pkg::BYTE_W-1:0]    in_byte,
    input  wire logic                          in_start,
    input  wire logic [dlr_pkg::TARGET_W-1:0]  in_target,
    output logic                               in_full,
    output logic                               cmd_push,
    output dlr_pkg::cmd_t                      cmd,
    input  wire logic                          cmd_full
);

    localparam logic [dlr_pkg::NIB_W-1:0] MAX_SIZE = dlr_pkg::NIB_W'(FIELD_BYTES);

    logic          valid_reg, valid_next;
    dlr_pkg::cmd_t cmd_reg, cmd_next;
    logic          take;
    logic [dlr_pkg::NIB_W-1:0] nl, ns;

    assign in_full  = valid_reg && cmd_full;
    assign take     = in_push && !in_full;
    assign cmd_push = valid_reg && !cmd_full;
    assign cmd      = cmd_reg;

    assign nl = in_byte[dlr_pkg::NIB_W-1:0];
    assign ns = in_byte[dlr_pkg::BYTE_W-1:dlr_pkg::NIB_W];

    always_comb
    begin
        cmd_next          = cmd_reg;
        cmd_next.run_byte = in_byte;
        cmd_next.start    = in_start;
        cmd_next.target   = in_target;
        cmd_next.hdr_zero = (nl == '0);
        cmd_next.hdr_wide = (nl > MAX_SIZE) || (ns > MAX_SIZE);
        cmd_next.len_size = nl;
        cmd_next.off_size = ns;
        valid_next        = take || (valid_reg && cmd_full);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cmd_reg <= cmd_next;
        end
    end

endmodule
`default_nettype wire

// File: rtl/dlr_back.sv
// Back end: run list walker with length, base and remainder arithmetic.
`timescale 1ns / 1ps
`default_nettype none
module dlr_back #(
    parameter int FIELD_BYTES = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire dlr_pkg::cmd_t    cmd,
    input  wire logic             cmd_empty,
    input  wire logic             res_full,
    output dlr_pkg::res_t         res,
    output dlr_pkg::bk_ctl_t      ctl
);

    localparam int LEN_W = 8 * FIELD_BYTES;
    localparam int BW    = dlr_pkg::BASE_W;
    localparam int TW    = dlr_pkg::TARGET_W;
    localparam int IW    = dlr_pkg::IDX_W;
    localparam int NW    = dlr_pkg::NIB_W;

    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_HEADER = 2'd1;
    localparam logic [1:0] PH_LENGTH = 2'd2;
    localparam logic [1:0] PH_DELTA  = 2'd3;

    logic [1:0]       phase_reg, phase_next;
    logic [NW-1:0]    left_reg, left_next;
    logic [NW-1:0]    off_reg, off_next;
    logic [IW-1:0]    idx_reg, idx_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [BW-1:0]    abs_reg, abs_next;   // running base plus remainder
    logic [TW-1:0]    rem_reg, rem_next;
    logic             hit_reg, hit_next;

    logic             step, emit;
    logic [1:0]       ph_eff;
    logic [TW-1:0]    rem_eff, rem_sub;
    logic [BW-1:0]    abs_eff, abs_sub, abs_add, part;
    logic [LEN_W-1:0] len_new;
    logic [NW-1:0]    left_dec;
    logic             hit, sign, out_of_range;

    assign step     = !cmd_empty && !res_full;
    assign ph_eff   = cmd.start ? PH_HEADER : phase_reg;
    assign rem_eff  = cmd.start ? cmd.target : rem_reg;
    assign abs_eff  = cmd.start ? BW'(cmd.target) : abs_reg;
    assign left_dec = NW'(left_reg - 1'b1);
    assign sign     = (left_reg == NW'(1)) && cmd.run_byte[dlr_pkg::BYTE_W-1];

    always_comb
    begin
        for (int k = 0; k < FIELD_BYTES; k++)
        begin
            len_new[8*k +: 8] = len_reg[8*k +: 8]
                              | ((idx_reg == IW'(k)) ? cmd.run_byte : 8'h00);
        end
        // delta byte in place, top byte sign-extended upwards
        for (int k = 0; k < dlr_pkg::LANES; k++)
        begin
            if (idx_reg == IW'(k))
            begin
                part[8*k +: 8] = cmd.run_byte;
            end
            else if (sign && (IW'(k) > idx_reg))
            begin
                part[8*k +: 8] = 8'hFF;
            end
            else
            begin
                part[8*k +: 8] = 8'h00;
            end
        end
    end

    assign hit          = BW'(rem_eff) < BW'(len_new);
    assign rem_sub      = rem_eff - TW'(len_new);
    assign abs_sub      = abs_eff - BW'(len_new);
    assign abs_add      = abs_eff + part;
    assign out_of_range = |abs_add[BW-1:dlr_pkg::CLUSTER_BITS];

    always_comb
    begin
        phase_next  = phase_reg;
        left_next   = left_reg;
        off_next    = off_reg;
        idx_next    = idx_reg;
        len_next    = len_reg;
        abs_next    = abs_reg;
        rem_next    = rem_reg;
        hit_next    = hit_reg;
        emit        = 1'b0;
        res.status  = dlr_pkg::ST_MAPPED;
        res.cluster = '0;
        if (step)
        begin
            phase_next = ph_eff;
            rem_next   = rem_eff;
            abs_next   = abs_eff;
            case (ph_eff)
                PH_HEADER:
                begin
                    if (cmd.hdr_zero)
                    begin
                        emit       = 1'b1;
                        res.status = dlr_pkg::ST_END;
                    end
                    else if (cmd.hdr_wide)
                    begin
                        emit       = 1'b1;
                        res.status = dlr_pkg::ST_WIDE;
                    end
                    else
                    begin
                        off_next   = cmd.off_size;
                        left_next  = cmd.len_size;
                        idx_next   = '0;
                        len_next   = '0;
                        phase_next = PH_LENGTH;
                    end
                end
                PH_LENGTH:
                begin
                    len_next  = len_new;
                    idx_next  = IW'(idx_reg + 1'b1);
                    left_next = left_dec;
                    if (left_dec == '0)
                    begin
                        // the hit test needs only the length, so it is taken here
                        hit_next = hit;
                        if (!hit)
                        begin
                            rem_next = rem_sub;
                            abs_next = abs_sub;
                        end
                        if (off_reg == '0)
                        begin
                            if (hit)
                            begin
                                emit       = 1'b1;
                                res.status = dlr_pkg::ST_SPARSE;
                            end
                            else
                            begin
                                phase_next = PH_HEADER;
                            end
                        end
                        else
                        begin
                            left_next  = off_reg;
                            idx_next   = '0;
                            phase_next = PH_DELTA;
                        end
                    end
                end
                PH_DELTA:
                begin
                    abs_next  = abs_add;
                    idx_next  = IW'(idx_reg + 1'b1);
                    left_next = left_dec;
                    if (left_dec == '0)
                    begin
                        if (hit_reg)
                        begin
                            emit = 1'b1;
                            if (out_of_range)
                            begin
                                res.status = dlr_pkg::ST_NEG;
                            end
                            else
                            begin
                                res.status  = dlr_pkg::ST_MAPPED;
                                res.cluster = abs_add[dlr_pkg::CLUSTER_W-1:0];
                            end
                        end
                        else
                        begin
                            phase_next = PH_HEADER;
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
            if (emit)
            begin
                phase_next = PH_IDLE;
            end
        end
    end

    assign ctl.cmd_pop  = step;
    assign ctl.res_push = emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            left_reg  <= '0;
            off_reg   <= '0;
            idx_reg   <= '0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            left_reg  <= left_next;
            off_reg   <= off_next;
            idx_reg   <= idx_next;
            hit_reg   <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg <= len_next;
        abs_reg <= abs_next;
        rem_reg <= rem_next;
    end

endmodule
`default_nettype wire

// File: test/dlr_checker.sv
// Checker for the run list decoder: predicts lookup results from accepted requests and compares.
`timescale 1ns / 1ps
module dlr_checker #(
    parameter int FIELD_BYTES = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    input  logic                            full,
    input  logic [dlr_pkg::BYTE_W-1:0]      run_byte,
    input  logic                            start_lookup,
    input  logic [dlr_pkg::TARGET_W-1:0]    target_rel,
    input  logic                            empty,
    input  logic                            pop,
    input  logic [dlr_pkg::STATUS_W-1:0]    status,
    input  logic [dlr_pkg::CLUSTER_W-1:0]   cluster,
    output int                              mismatch_count,
    output int                              pending,
    output int                              sent_bytes
);

    typedef enum logic [1:0] {
        W_IDLE,
        W_HEADER,
        W_LENGTH,
        W_DELTA
    } walk_phase_t;

    walk_phase_t               walk_phase;
    logic [dlr_pkg::NIB_W-1:0] left_cnt;
    logic [dlr_pkg::NIB_W-1:0] delta_bytes;
    logic [dlr_pkg::IDX_W-1:0] lane;
    logic [63:0]               run_len;
    logic [63:0]               base;
    logic [63:0]               rel_left;
    logic                      in_sparse;

    dlr_pkg::res_t lookup_results_q[$];

    // End of a run: either the target lies inside it or we move on to the next header
    function automatic bit close_run(output dlr_pkg::res_t r);
        logic [63:0] abs_cl;
        r = '0;
        if (rel_left < run_len)
        begin
            walk_phase = W_IDLE;
            if (in_sparse)
            begin
                r.status = dlr_pkg::ST_SPARSE;
            end
            else
            begin
                abs_cl = base + rel_left;
                if (abs_cl[63] || abs_cl[63:dlr_pkg::CLUSTER_BITS] != '0)
                begin
                    r.status = dlr_pkg::ST_NEG;
                end
                else
                begin
                    r.status  = dlr_pkg::ST_MAPPED;
                    r.cluster = abs_cl[dlr_pkg::CLUSTER_W-1:0];
                end
            end
            return 1'b1;
        end
        rel_left   = rel_left - run_len;
        walk_phase = W_HEADER;
        return 1'b0;
    endfunction

    // One run-list byte; returns 1 when the lookup ends with a result
    function automatic bit walk_byte(input logic [dlr_pkg::BYTE_W-1:0] b, input logic st,
                                     input logic [dlr_pkg::TARGET_W-1:0] tgt,
                                     output dlr_pkg::res_t r);
        logic [dlr_pkg::NIB_W-1:0] len_sz;
        logic [dlr_pkg::NIB_W-1:0] off_sz;
        logic [63:0]               part;
        bit                        hit;
        r   = '0;
        hit = 1'b0;
        if (st)
        begin
            base       = '0;
            run_len    = '0;
            rel_left   = {16'b0, tgt};
            walk_phase = W_HEADER;
        end
        len_sz = b[3:0];
        off_sz = b[7:4];
        case (walk_phase)
            W_HEADER:
            begin
                if (len_sz == 0)
                begin
                    r.status   = dlr_pkg::ST_END;
                    walk_phase = W_IDLE;
                    hit        = 1'b1;
                end
                else if (len_sz > FIELD_BYTES || off_sz > FIELD_BYTES)
                begin
                    r.status   = dlr_pkg::ST_WIDE;
                    walk_phase = W_IDLE;
                    hit        = 1'b1;
                end
                else
                begin
                    in_sparse   = (off_sz == 0);
                    delta_bytes = off_sz;
                    left_cnt    = len_sz;
                    lane        = '0;
                    run_len     = '0;
                    walk_phase  = W_LENGTH;
                end
            end
            W_LENGTH:
            begin
                run_len  = run_len | ({56'b0, b} << (8 * lane));
                lane     = lane + 1'b1;
                left_cnt = left_cnt - 1'b1;
                if (left_cnt == 0)
                begin
                    if (delta_bytes == 0)
                    begin
                        hit = close_run(r);
                    end
                    else
                    begin
                        left_cnt   = delta_bytes;
                        lane       = '0;
                        walk_phase = W_DELTA;
                    end
                end
            end
            W_DELTA:
            begin
                part = {56'b0, b} << (8 * lane);
                // top delta byte carries the sign
                if (left_cnt == 1 && b[7] && lane != 3'd7)
                    part = part | ({64{1'b1}} << (8 * lane + 8));
                base     = base + part;
                lane     = lane + 1'b1;
                left_cnt = left_cnt - 1'b1;
                if (left_cnt == 0)
                    hit = close_run(r);
            end
            default: ;
        endcase
        return hit;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        dlr_pkg::res_t got;
        dlr_pkg::res_t want;
        if (!rst_n)
        begin
            walk_phase  = W_IDLE;
            left_cnt    = '0;
            delta_bytes = '0;
            lane        = '0;
            run_len     = '0;
            base        = '0;
            rel_left    = '0;
            in_sparse   = 1'b0;
            lookup_results_q.delete();
            mismatch_count = 0;
            pending        = 0;
            sent_bytes     = 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                got.status  = status;
                got.cluster = cluster;
                if (lookup_results_q.size() == 0)
                begin
                    $error("result with nothing expected: status %0d cluster 0x%0h",
                           got.status, got.cluster);
                    mismatch_count++;
                end
                else
                begin
                    want = lookup_results_q.pop_front();
                    if (got.status !== want.status)
                    begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, got.status);
                        mismatch_count++;
                    end
                    if (got.cluster !== want.cluster)
                    begin
                        $error("cluster mismatch: expected 0x%0h, actual 0x%0h",
                               want.cluster, got.cluster);
                        mismatch_count++;
                    end
                end
            end
            if (push && !full)
            begin
                // every accepted request counts, including ones the block drops
                sent_bytes++;
                if (walk_byte(run_byte, start_lookup, target_rel, want))
                    lookup_results_q.push_back(want);
            end
            pending = lookup_results_q.size();
        end
    end

endmodule

// File: test/tb_top.sv
// Testbench top for the run list decoder: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps
module tb_top;

    localparam int ITEMS          = 1550;  // accepted requests over the whole run
    localparam int WATCHDOG_LIMIT = 4000;  // cycles with no handshake on either side
    localparam int SETTLE_CYCLES  = 30;    // idle wait before the final verdict

    logic                          clk          = 1'b0;
    logic                          rst_n        = 1'b0;
    logic                          push         = 1'b0;
    logic                          pop          = 1'b0;
    logic                          start_lookup = 1'b0;
    logic [dlr_pkg::BYTE_W-1:0]    run_byte     = '0;
    logic [dlr_pkg::TARGET_W-1:0]  target_rel   = '0;
    logic                          full;
    logic                          empty;
    logic [dlr_pkg::STATUS_W-1:0]  status;
    logic [dlr_pkg::CLUSTER_W-1:0] cluster;

    int fail_count;
    int pending;
    int sent_bytes;
    int idle_pct     = 0;  // chance per cycle that the sender holds back
    int stall_pct    = 0;  // chance per cycle that the receiver holds pop low
    int quiet_cycles = 0;

    data_run_list_decoder_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .run_byte     (run_byte),
        .start_lookup (start_lookup),
        .target_rel   (target_rel),
        .empty        (empty),
        .pop          (pop),
        .status       (status),
        .cluster      (cluster)
    );

    dlr_checker chk (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .run_byte       (run_byte),
        .start_lookup   (start_lookup),
        .target_rel     (target_rel),
        .empty          (empty),
        .pop            (pop),
        .status         (status),
        .cluster        (cluster),
        .mismatch_count (fail_count),
        .pending        (pending),
        .sent_bytes     (sent_bytes)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // Result side: pop held low at random, rate set by the current phase
    always @(posedge clk)
    begin
        pop <= ($urandom_range(99) >= stall_pct);
    end

    // Watchdog: any request or result handshake restarts the count
    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    function automatic logic [dlr_pkg::TARGET_W-1:0] rand48();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[dlr_pkg::TARGET_W-1:0];
    endfunction

    // Offer one request, with random idle cycles first, and hold it until taken.
    // Called on a rising edge; returns on the edge at which the request went in.
    task automatic put_byte(input logic [dlr_pkg::BYTE_W-1:0] b, input logic st,
                            input logic [dlr_pkg::TARGET_W-1:0] tgt);
        while ($urandom_range(99) < idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push         <= 1'b1;
        run_byte     <= b;
        start_lookup <= st;
        target_rel   <= tgt;
        @(posedge clk);
        while (full)
            @(posedge clk);
    endtask

    // Sender holds off until every expected result has come out
    task automatic drain();
        push <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // One lookup: a mostly well-formed run list with random content, a target that
    // usually lands inside it, and now and then a broken or cut-short list.
    task automatic send_lookup();
        logic [dlr_pkg::BYTE_W-1:0]   list_q[$];
        logic [dlr_pkg::BYTE_W-1:0]   b;
        logic [63:0]                  total;
        logic [63:0]                  len_val;
        logic [dlr_pkg::TARGET_W-1:0] tgt;
        int                           runs;
        int                           nl;
        int                           ns;
        int                           pick;
        int                           cut;
        total = '0;
        if ($urandom_range(99) < 4)
            put_byte(8'($urandom_range(255)), 1'b0, rand48());  // stray byte, normally dropped
        if ($urandom_range(99) < 10)
        begin
            // noise: raw random bytes behind a start
            repeat ($urandom_range(1, 12))
                list_q.push_back(8'($urandom_range(255)));
        end
        else
        begin
            runs = int'($urandom_range(1, 4));
            for (int k = 0; k < runs; k++)
            begin
                nl   = ($urandom_range(9) == 0) ? 8 : int'($urandom_range(1, 3));
                pick = int'($urandom_range(99));
                if (pick < 20)
                    ns = 0;                       // sparse run
                else if (pick < 30)
                    ns = int'($urandom_range(7, 8));
                else
                    ns = int'($urandom_range(1, 4));
                list_q.push_back({4'(ns), 4'(nl)});
                len_val = '0;
                for (int i = 0; i < nl; i++)
                begin
                    // upper length bytes mostly zero so targets can reach later runs
                    b = (i == 0 || $urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'h00;
                    list_q.push_back(b);
                    len_val = len_val | (64'(b) << (8 * i));
                end
                total = (total + len_val < total) ? {64{1'b1}} : total + len_val;
                for (int i = 0; i < ns; i++)
                begin
                    b = 8'($urandom_range(255));
                    if (i == ns - 1 && $urandom_range(3) != 0)
                        b[7] = 1'b0;                  // keep most deltas forward
                    list_q.push_back(b);
                end
            end
            list_q.push_back({4'($urandom_range(15)), 4'h0});  // end of list
        end

        pick = int'($urandom_range(99));
        if (total == 0 || total[63:dlr_pkg::TARGET_W] != '0 || pick < 13)
            tgt = rand48();
        else if (pick < 25)
            tgt = total[dlr_pkg::TARGET_W-1:0];   // just past the last run
        else
            tgt = 48'({$urandom, $urandom} % total);

        cut = list_q.size();
        if (list_q.size() > 1 && $urandom_range(99) < 8)
            cut = int'($urandom_range(1, list_q.size() - 1));  // next start abandons this one

        for (int i = 0; i < cut; i++)
            put_byte(list_q[i], (i == 0), (i == 0) ? tgt : rand48());
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed requests
        put_byte(8'h31, 1'b0, rand48());                 // nothing open: dropped
        put_byte(8'h00, 1'b1, '0);                       // zero header: end of runs
        put_byte(8'h90, 1'b1, rand48());                 // zero length size wins over width
        put_byte(8'hF9, 1'b1, rand48());                 // both nibbles too wide
        put_byte(8'h01, 1'b1, 48'd5);                    // sparse run of 16
        put_byte(8'h10, 1'b0, rand48());
        put_byte(8'h11, 1'b1, 48'd3);                    // empty run skipped, base 5
        put_byte(8'h00, 1'b0, '0);
        put_byte(8'h05, 1'b0, '0);
        put_byte(8'h11, 1'b0, '0);                       // run of 8 at 0x25: maps to 0x28
        put_byte(8'h08, 1'b0, '0);
        put_byte(8'h20, 1'b0, '0);
        put_byte(8'h11, 1'b1, '0);                       // delta -16: negative cluster
        put_byte(8'h04, 1'b0, '0);
        put_byte(8'hF0, 1'b0, '0);
        put_byte(8'h11, 1'b1, rand48());                 // restart part-way through
        put_byte(8'h00, 1'b1, rand48());
        put_byte(8'h08, 1'b1, {dlr_pkg::TARGET_W{1'b1}}); // widest length, top target
        repeat (8)
            put_byte(8'hFF, 1'b0, '0);
        drain();

        // Random lookups in four phases of back-pressure, draining between them
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct  = 76;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct  = 0;
                    stall_pct = 76;
                end
                default:
                begin
                    idle_pct  = 17;
                    stall_pct = 17;
                end
            endcase
            while (sent_bytes < ITEMS * (ph + 1) / 4)
                send_lookup();
            drain();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
